@@ rtl/mbal_pkg.sv @@
// Shared constants, request/response types and square-table entry for the attack lookup.
`timescale 1ns / 1ps
`default_nettype none
package mbal_pkg;

    // Board and word geometry
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = WORD_W / 2;
    localparam int unsigned SQUARES = 64;
    localparam int unsigned SQ_W    = $clog2(SQUARES);
    localparam int unsigned BITS_W  = 4;

    // Attack memory sizing
    localparam int unsigned ATTACK_DEPTH   = 131072;
    localparam int unsigned MAX_INDEX_BITS = 12;
    localparam int unsigned ATTACK_AW      = $clog2(ATTACK_DEPTH);
    localparam int unsigned OFFSET_W       = ATTACK_AW + 1;
    localparam int unsigned INDEX_W        = MAX_INDEX_BITS;
    // wide enough for offset + block size and base + index without wrap
    localparam int unsigned SUM_W =
        ((OFFSET_W > MAX_INDEX_BITS + 1) ? OFFSET_W : MAX_INDEX_BITS + 1) + 1;

    // Request kinds
    localparam logic [1:0] KIND_LOAD_BLOCK = 2'd0;
    localparam logic [1:0] KIND_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] KIND_QUERY      = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SQ_W-1:0]   square;
        logic [WORD_W-1:0] occupancy;
        logic [WORD_W-1:0] relevant_mask;
        logic [WORD_W-1:0] magic_factor;
        logic [BITS_W-1:0] index_bits;
        logic [WORD_W-1:0] attack_in;
    } mbal_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] attack_out;
        logic              status;
    } mbal_rsp_t;

    // One square's parameters as held in the square table
    typedef struct packed {
        logic [WORD_W-1:0]    mask;
        logic [WORD_W-1:0]    magic;
        logic [BITS_W-1:0]    bits;
        logic [ATTACK_AW-1:0] base;
    } mbal_sq_entry_t;

    // Hash unit handshake
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
        logic [WORD_W-1:0] magic;
        logic [BITS_W-1:0] bits;
    } mbal_hash_req_t;

    typedef struct packed {
        logic               done;
        logic [INDEX_W-1:0] index;
    } mbal_hash_rsp_t;

endpackage
`default_nettype wire

@@ rtl/mbal_ram.sv @@
// Generic single-clock RAM, one write and one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mbal_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/mbal_hash.sv @@
// Magic hash unit: low 64 bits of operand * magic over a shared 32x32 multiplier, top bits out.
`timescale 1ns / 1ps
`default_nettype none
module mbal_hash (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mbal_pkg::mbal_hash_req_t hash_req,
    output mbal_pkg::mbal_hash_rsp_t      hash_rsp
);

    localparam logic [2:0] STEP_IDLE = 3'd0;
    localparam logic [2:0] STEP_LL   = 3'd1;  // lo * lo
    localparam logic [2:0] STEP_LH   = 3'd2;  // lo * hi
    localparam logic [2:0] STEP_HL   = 3'd3;  // hi * lo
    localparam logic [2:0] STEP_SUM  = 3'd4;  // fold last cross term
    localparam logic [2:0] STEP_DONE = 3'd5;

    logic [2:0]                          step_reg;
    logic [2:0]                          step_next;
    logic [mbal_pkg::WORD_W-1:0]         a_reg;
    logic [mbal_pkg::WORD_W-1:0]         b_reg;
    logic [mbal_pkg::BITS_W-1:0]         bits_reg;
    logic [mbal_pkg::WORD_W-1:0]         prod_reg;
    logic [mbal_pkg::WORD_W-1:0]         acc_reg;
    logic [mbal_pkg::HALF_W-1:0]         mul_a;
    logic [mbal_pkg::HALF_W-1:0]         mul_b;
    logic [mbal_pkg::WORD_W-1:0]         mul_p;
    logic [mbal_pkg::INDEX_W-1:0]        top_bits;
    logic [mbal_pkg::BITS_W-1:0]         shamt;

    // Operand halves for the shared multiplier
    always_comb
    begin
        mul_a = (step_reg == STEP_HL) ? a_reg[mbal_pkg::WORD_W-1:mbal_pkg::HALF_W]
                                      : a_reg[mbal_pkg::HALF_W-1:0];
        mul_b = (step_reg == STEP_LH) ? b_reg[mbal_pkg::WORD_W-1:mbal_pkg::HALF_W]
                                      : b_reg[mbal_pkg::HALF_W-1:0];
        mul_p = {{mbal_pkg::HALF_W{1'b0}}, mul_a} * {{mbal_pkg::HALF_W{1'b0}}, mul_b};
    end

    // Step sequencer
    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            STEP_IDLE: if (hash_req.start) step_next = STEP_LL;
            STEP_LL:   step_next = STEP_LH;
            STEP_LH:   step_next = STEP_HL;
            STEP_HL:   step_next = STEP_SUM;
            STEP_SUM:  step_next = STEP_DONE;
            STEP_DONE: step_next = STEP_IDLE;
            default:   step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Datapath: operands, product and accumulated low word
    always_ff @(posedge clk)
    begin
        case (step_reg)
            STEP_IDLE:
            begin
                if (hash_req.start)
                begin
                    a_reg    <= hash_req.operand;
                    b_reg    <= hash_req.magic;
                    bits_reg <= hash_req.bits;
                end
            end
            STEP_LL:
            begin
                prod_reg <= mul_p;
            end
            STEP_LH:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            STEP_HL:
            begin
                acc_reg[mbal_pkg::WORD_W-1:mbal_pkg::HALF_W] <=
                    acc_reg[mbal_pkg::WORD_W-1:mbal_pkg::HALF_W] +
                    prod_reg[mbal_pkg::HALF_W-1:0];
                prod_reg <= mul_p;
            end
            STEP_SUM:
            begin
                acc_reg[mbal_pkg::WORD_W-1:mbal_pkg::HALF_W] <=
                    acc_reg[mbal_pkg::WORD_W-1:mbal_pkg::HALF_W] +
                    prod_reg[mbal_pkg::HALF_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Index: top 'bits' bits of the product; a count of zero shifts everything out
    always_comb
    begin
        top_bits       = acc_reg[mbal_pkg::WORD_W-1 -: mbal_pkg::INDEX_W];
        shamt          = mbal_pkg::BITS_W'(mbal_pkg::MAX_INDEX_BITS) - bits_reg;
        hash_rsp.done  = (step_reg == STEP_DONE);
        hash_rsp.index = top_bits >> shamt;
    end

endmodule
`default_nettype wire

@@ rtl/magic_bitboard_attack_lookup_top.sv @@
// One request in flight; the next is taken once its response is registered, and a finished
// request holds until the previous response is taken. A query passes the registered
// square-table read, the four-step 32x32 hash multiply and the registered attack-memory read;
// an entry load passes the table read and the hash before its write; a block load only its capacity check.
// Reset clears the sequencer, the response valid and the running offset; table and attack
// memories are not cleared and hold nothing meaningful until loaded.
`timescale 1ns / 1ps
`default_nettype none
module magic_bitboard_attack_lookup_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire mbal_pkg::mbal_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output mbal_pkg::mbal_rsp_t      rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_TREAD = 3'd2;
    localparam logic [2:0] S_HASH  = 3'd3;
    localparam logic [2:0] S_ADDR  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam int unsigned ENTRY_W = $bits(mbal_pkg::mbal_sq_entry_t);

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    mbal_pkg::mbal_req_t               req_reg;
    logic [mbal_pkg::OFFSET_W-1:0]     next_offset_reg;
    logic [mbal_pkg::OFFSET_W-1:0]     next_offset_next;
    logic [mbal_pkg::WORD_W-1:0]       res_attack_reg;
    logic                              res_status_reg;
    logic [mbal_pkg::SUM_W-1:0]        addr_reg;
    logic                              in_range_reg;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    mbal_pkg::mbal_rsp_t               rsp_reg;

    logic                              accept;
    logic                              out_free;
    logic [mbal_pkg::BITS_W-1:0]       sat_bits;
    logic [mbal_pkg::OFFSET_W-1:0]     start_off;
    logic [mbal_pkg::SUM_W-1:0]        blk_end;
    logic                              overflow;
    logic [mbal_pkg::SUM_W-1:0]        addr_sum;

    logic                              tbl_wr_en;
    mbal_pkg::mbal_sq_entry_t          tbl_wr;
    logic [ENTRY_W-1:0]                tbl_rd_data;
    mbal_pkg::mbal_sq_entry_t          tbl_rd;
    logic                              atk_wr_en;
    logic                              atk_rd_en;
    logic [mbal_pkg::WORD_W-1:0]       atk_rd_data;

    mbal_pkg::mbal_hash_req_t          hash_req;
    mbal_pkg::mbal_hash_rsp_t          hash_rsp;

    // Handshake
    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Block load: base from running offset (restarting at zero for square 0), capacity check
    always_comb
    begin
        sat_bits  = (req_reg.index_bits > mbal_pkg::BITS_W'(mbal_pkg::MAX_INDEX_BITS))
                    ? mbal_pkg::BITS_W'(mbal_pkg::MAX_INDEX_BITS) : req_reg.index_bits;
        start_off = (req_reg.square == '0) ? '0 : next_offset_reg;
        blk_end   = mbal_pkg::SUM_W'(start_off) + (mbal_pkg::SUM_W'(1) << sat_bits);
        overflow  = blk_end > mbal_pkg::SUM_W'(mbal_pkg::ATTACK_DEPTH);
    end

    // Square table write on an accepted block load
    always_comb
    begin
        tbl_wr_en    = (state_reg == S_LOAD) && !overflow;
        tbl_wr.mask  = req_reg.relevant_mask;
        tbl_wr.magic = req_reg.magic_factor;
        tbl_wr.bits  = sat_bits;
        tbl_wr.base  = start_off[mbal_pkg::ATTACK_AW-1:0];
    end

    assign tbl_rd = mbal_pkg::mbal_sq_entry_t'(tbl_rd_data);

    mbal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (mbal_pkg::SQUARES)
    ) u_sq_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (req_reg.square),
        .wr_data (tbl_wr),
        .rd_en   (accept),
        .rd_addr (req.square),
        .rd_data (tbl_rd_data)
    );

    // Hash start once the square's parameters are out of the table
    always_comb
    begin
        hash_req.start   = (state_reg == S_TREAD);
        hash_req.operand = req_reg.occupancy & tbl_rd.mask;
        hash_req.magic   = tbl_rd.magic;
        hash_req.bits    = tbl_rd.bits;
    end

    mbal_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .hash_req (hash_req),
        .hash_rsp (hash_rsp)
    );

    assign addr_sum = mbal_pkg::SUM_W'(tbl_rd.base) + mbal_pkg::SUM_W'(hash_rsp.index);

    // Attack memory access
    assign atk_wr_en = (state_reg == S_ADDR) && in_range_reg
                       && (req_reg.kind == mbal_pkg::KIND_LOAD_ENTRY);
    assign atk_rd_en = (state_reg == S_ADDR) && in_range_reg
                       && (req_reg.kind == mbal_pkg::KIND_QUERY);

    mbal_ram #(
        .WIDTH (mbal_pkg::WORD_W),
        .DEPTH (mbal_pkg::ATTACK_DEPTH)
    ) u_attack_mem (
        .clk     (clk),
        .wr_en   (atk_wr_en),
        .wr_addr (addr_reg[mbal_pkg::ATTACK_AW-1:0]),
        .wr_data (req_reg.attack_in),
        .rd_en   (atk_rd_en),
        .rd_addr (addr_reg[mbal_pkg::ATTACK_AW-1:0]),
        .rd_data (atk_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        next_offset_next = next_offset_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        mbal_pkg::KIND_LOAD_BLOCK: state_next = S_LOAD;
                        mbal_pkg::KIND_LOAD_ENTRY,
                        mbal_pkg::KIND_QUERY:      state_next = S_TREAD;
                        default:                   state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (!overflow)
                begin
                    next_offset_next = blk_end[mbal_pkg::OFFSET_W-1:0];
                end
                state_next = S_DONE;
            end
            S_TREAD: state_next = S_HASH;
            S_HASH:  if (hash_rsp.done) state_next = S_ADDR;
            S_ADDR:  state_next = (req_reg.kind == mbal_pkg::KIND_QUERY) ? S_READ : S_DONE;
            S_READ:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            next_offset_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_offset_reg <= next_offset_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg        <= req;
            res_attack_reg <= '0;
            res_status_reg <= 1'b0;
        end
        if (state_reg == S_LOAD)
        begin
            res_status_reg <= overflow;
        end
        if ((state_reg == S_HASH) && hash_rsp.done)
        begin
            addr_reg     <= addr_sum;
            in_range_reg <= addr_sum < mbal_pkg::SUM_W'(mbal_pkg::ATTACK_DEPTH);
        end
        if ((state_reg == S_READ) && in_range_reg)
        begin
            res_attack_reg <= atk_rd_data;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            rsp_reg.attack_out <= res_attack_reg;
            rsp_reg.status     <= res_status_reg;
        end
    end

`ifndef SYNTHESIS
    // Hash unit only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_rsp.done |-> (state_reg == S_HASH))
        else $error("hash done outside hash wait");

    // Running offset never passes the attack memory capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        next_offset_reg <= mbal_pkg::OFFSET_W'(mbal_pkg::ATTACK_DEPTH))
        else $error("running offset beyond attack memory");

    // Attack memory written only for an in-range entry load
    assert property (@(posedge clk) disable iff (!rst_n)
        atk_wr_en |-> (req_reg.kind == mbal_pkg::KIND_LOAD_ENTRY) && in_range_reg
                      && (addr_reg < mbal_pkg::SUM_W'(mbal_pkg::ATTACK_DEPTH)))
        else $error("attack write out of range or wrong kind");

    // Read data capture follows the memory read cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ($past(state_reg) == S_ADDR))
        else $error("read capture without preceding address cycle");
`endif

endmodule
`default_nettype wire
